/* src/power_unit_command_controller_top_defines.svh */
// ----------------------------------------------------------------------------
// power_unit_command_controller_top_defines
// Shared assertion macros for the power unit command controller checker.
// ----------------------------------------------------------------------------
`ifndef POWER_UNIT_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define POWER_UNIT_COMMAND_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PUCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pucc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PUCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pucc assertion failed");

`endif

/* src/pucc_pkg.sv */
// ----------------------------------------------------------------------------
// pucc_pkg
// Opcodes, response codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pucc_pkg;

  localparam logic [7:0] OP_STATUS    = 8'h0A;
  localparam logic [7:0] OP_STOP      = 8'h05;
  localparam logic [7:0] OP_CHARGE    = 8'h02;
  localparam logic [7:0] OP_GEN       = 8'h04;
  localparam logic [7:0] OP_DISCHARGE = 8'h03;
  localparam logic [7:0] OP_PROTECT   = 8'h06;
  localparam logic [7:0] OP_SERIAL    = 8'h0F;
  localparam logic [7:0] OP_COEFF     = 8'h07;

  localparam logic [7:0] RC_STATUS    = 8'hF5;
  localparam logic [7:0] RC_STOP      = 8'hFA;
  localparam logic [7:0] RC_CHARGE    = 8'hFD;
  localparam logic [7:0] RC_GEN       = 8'hFB;
  localparam logic [7:0] RC_DISCHARGE = 8'hFC;
  localparam logic [7:0] RC_PROTECT   = 8'hF9;
  localparam logic [7:0] RC_COEFF     = 8'hF8;

  localparam logic [1:0] MODE_STOP      = 2'd0;
  localparam logic [1:0] MODE_CHARGE    = 2'd1;
  localparam logic [1:0] MODE_GEN       = 2'd2;
  localparam logic [1:0] MODE_DISCHARGE = 2'd3;

  localparam logic [1:0] KIND_REJ    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_SERIAL = 2'd2;
  localparam logic [1:0] KIND_COEFF  = 2'd3;

  localparam logic [1:0] SEL_HEAD = 2'd0;
  localparam logic [1:0] SEL_LO   = 2'd1;
  localparam logic [1:0] SEL_HI   = 2'd2;
  localparam logic [1:0] SEL_REJ  = 2'd3;

  localparam logic [3:0] HLEN_STATUS = 4'd2;
  localparam logic [3:0] HLEN_COEFF  = 4'd4;
  localparam logic [3:0] HLEN_SERIAL = 4'd9;
  localparam logic [3:0] K_MAX       = 4'd15;

  localparam logic [27:0] SCALE_DIV = 28'd4095;

  typedef struct packed {
    logic       sample_wr;
    logic       accept;
    logic       load_mul;
    logic       load_div;
    logic       fix;
    logic       emit;
    logic [1:0] emit_sel;
    logic       last;
    logic       sens_inc;
    logic [3:0] k;
  } pucc_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fix_done;
    logic       sens_last;
  } pucc_stat_t;

  function automatic logic [7:0] serial_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = 8'hF0;
      4'd1:    b = 8'h03;
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/pucc_ctrl.sv */
// ----------------------------------------------------------------------------
// pucc_ctrl
// Sequencer: steps header bytes, scaling and sample bytes of a response.
// ----------------------------------------------------------------------------
`default_nettype none

module pucc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 req_type,
  input  wire pucc_pkg::pucc_stat_t stat,
  output pucc_pkg::pucc_cmd_t       cmd,
  output logic                      busy,
  output logic                      resp_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_LO    = 3'd6;
  localparam logic [2:0] S_HI    = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] k, k_next;
  logic [3:0] hlen;
  logic       valid;

  assign busy       = (state != S_IDLE) || valid;
  assign resp_valid = valid;

  always_comb begin
    unique case (stat.kind)
      pucc_pkg::KIND_COEFF:  hlen = pucc_pkg::HLEN_COEFF;
      pucc_pkg::KIND_SERIAL: hlen = pucc_pkg::HLEN_SERIAL;
      default:               hlen = pucc_pkg::HLEN_STATUS;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.k      = k;
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          if (req_type) begin
            cmd.sample_wr = 1'b1;
          end else begin
            cmd.accept = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_START: begin
        k_next = '0;
        if (stat.kind == pucc_pkg::KIND_REJ) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = pucc_pkg::SEL_REJ;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = pucc_pkg::SEL_HEAD;
        k_next       = k + 4'd1;
        if (k == hlen - 4'd1) begin
          if (stat.kind == pucc_pkg::KIND_SERIAL) begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.load_div = 1'b1;
        state_next   = S_FIX;
      end
      S_FIX: begin
        if (stat.fix_done) begin
          state_next = S_LO;
        end else begin
          cmd.fix = 1'b1;
        end
      end
      S_LO: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = pucc_pkg::SEL_LO;
        k_next       = k + 4'd1;
        state_next   = S_HI;
      end
      default: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = pucc_pkg::SEL_HI;
        cmd.last     = (k == pucc_pkg::K_MAX) || (stat.kind == pucc_pkg::KIND_COEFF)
                       || stat.sens_last;
        if (cmd.last) begin
          state_next = S_IDLE;
        end else begin
          cmd.sens_inc = 1'b1;
          k_next       = k + 4'd1;
          state_next   = S_MUL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      valid <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

/* src/pucc_dp.sv */
// ----------------------------------------------------------------------------
// pucc_dp
// Mode, interlocks, tables, drive levels, scaling unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pucc_dp #(
  parameter int SENSORS = 7
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pucc_pkg::pucc_cmd_t cmd,
  output pucc_pkg::pucc_stat_t     stat,
  input  wire logic [7:0]          opcode,
  input  wire logic [7:0]          frame_len,
  input  wire logic [7:0]          arg_byte,
  input  wire logic [15:0]         coeff_value,
  input  wire logic [2:0]          sensor_index,
  input  wire logic [11:0]         sample_value,
  input  wire logic                timer_active,
  input  wire logic [4:0]          status_pins,
  output logic [7:0]               resp_byte,
  output logic                     resp_last,
  output logic                     rejected,
  output logic [7:0]               drive,
  output logic                     protect_reset,
  output logic                     timer_start,
  output logic [2:0]               coeff_store
);

  localparam int IW = $clog2(SENSORS);

  logic [1:0]  mode, mode_n;
  logic        fault, fault_n;
  logic [7:0]  drive_n;
  logic [15:0] coeff_tab [SENSORS];
  logic [11:0] sample_tab [SENSORS];
  logic [1:0]  kind, kind_n;
  logic [7:0]  code, code_n;
  logic        prot, prot_n, tmr, tmr_n;
  logic [2:0]  store, store_n;
  logic        cwr, arg0;
  logic [2:0]  idx, idx_r;
  logic        idx_ok;
  logic [4:0]  pins;
  logic [IW-1:0] sens, sel;
  logic [27:0] prod, r, sum;
  logic [15:0] q, q0;
  logic [15:0] cur_coeff;
  logic [7:0]  head, sbyte, obyte;

  always_comb begin
    idx    = '0;
    idx_ok = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (arg_byte[i+1]) begin
        idx    = 3'(i);
        idx_ok = 1'b1;
      end
    end
  end

  always_comb begin
    mode_n  = mode;
    fault_n = fault;
    drive_n = drive;
    kind_n  = pucc_pkg::KIND_REJ;
    code_n  = '0;
    prot_n  = 1'b0;
    tmr_n   = 1'b0;
    store_n = '0;
    cwr     = 1'b0;
    unique case (opcode)
      pucc_pkg::OP_STATUS: begin
        if (frame_len == 8'd1) begin
          kind_n = pucc_pkg::KIND_STATUS;
          code_n = pucc_pkg::RC_STATUS;
        end
      end
      pucc_pkg::OP_STOP: begin
        if (frame_len == 8'd1 && !timer_active) begin
          fault_n = 1'b0;
          unique case (mode)
            pucc_pkg::MODE_CHARGE: begin
              drive_n[4] = 1'b0;
              drive_n[3] = 1'b1;
            end
            pucc_pkg::MODE_GEN: drive_n[1] = 1'b0;
            default:            drive_n[0] = 1'b1;
          endcase
          tmr_n  = 1'b1;
          mode_n = pucc_pkg::MODE_STOP;
          kind_n = pucc_pkg::KIND_STATUS;
          code_n = pucc_pkg::RC_STOP;
        end
      end
      pucc_pkg::OP_CHARGE: begin
        if (frame_len == 8'd2 && !(timer_active && mode != pucc_pkg::MODE_CHARGE)
            && (mode == pucc_pkg::MODE_STOP || mode == pucc_pkg::MODE_CHARGE)) begin
          if (!status_pins[1]) begin
            fault_n = 1'b1;
          end else begin
            drive_n[4]   = arg_byte[0];
            drive_n[7:5] = arg_byte[4:2];
            if (mode == pucc_pkg::MODE_STOP) begin
              drive_n[2] = 1'b1;
              tmr_n      = 1'b1;
            end
            mode_n = pucc_pkg::MODE_CHARGE;
            kind_n = pucc_pkg::KIND_STATUS;
            code_n = pucc_pkg::RC_CHARGE;
          end
        end
      end
      pucc_pkg::OP_GEN: begin
        if (frame_len == 8'd1 && !(timer_active && mode != pucc_pkg::MODE_GEN)
            && (mode == pucc_pkg::MODE_STOP || mode == pucc_pkg::MODE_GEN)) begin
          if (!status_pins[0]) begin
            fault_n = 1'b1;
          end else begin
            if (mode == pucc_pkg::MODE_STOP) begin
              drive_n[1] = 1'b1;
              tmr_n      = 1'b1;
            end
            mode_n = pucc_pkg::MODE_GEN;
            kind_n = pucc_pkg::KIND_STATUS;
            code_n = pucc_pkg::RC_GEN;
          end
        end
      end
      pucc_pkg::OP_DISCHARGE: begin
        if (frame_len == 8'd1 && !(timer_active && mode != pucc_pkg::MODE_DISCHARGE)
            && (mode == pucc_pkg::MODE_STOP || mode == pucc_pkg::MODE_DISCHARGE)) begin
          if (mode == pucc_pkg::MODE_STOP) begin
            drive_n[0] = 1'b0;
            tmr_n      = 1'b1;
          end
          mode_n = pucc_pkg::MODE_DISCHARGE;
          kind_n = pucc_pkg::KIND_STATUS;
          code_n = pucc_pkg::RC_DISCHARGE;
        end
      end
      pucc_pkg::OP_PROTECT: begin
        if (frame_len == 8'd1) begin
          prot_n = 1'b1;
          kind_n = pucc_pkg::KIND_STATUS;
          code_n = pucc_pkg::RC_PROTECT;
        end
      end
      pucc_pkg::OP_SERIAL: begin
        if (frame_len == 8'd1) begin
          kind_n = pucc_pkg::KIND_SERIAL;
        end
      end
      pucc_pkg::OP_COEFF: begin
        if (frame_len == 8'd4 && idx_ok) begin
          kind_n = pucc_pkg::KIND_COEFF;
          code_n = pucc_pkg::RC_COEFF;
          if (coeff_value != 16'd0) begin
            cwr = 1'b1;
            if (!arg_byte[0]) begin
              store_n = idx + 3'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= pucc_pkg::MODE_STOP;
      fault <= 1'b0;
      drive <= '0;
      kind  <= pucc_pkg::KIND_REJ;
      for (int i = 0; i < SENSORS; i++) begin
        coeff_tab[i]  <= '0;
        sample_tab[i] <= '0;
      end
    end else begin
      if (cmd.sample_wr && (32'(sensor_index) < SENSORS)) begin
        sample_tab[sensor_index[IW-1:0]] <= sample_value;
      end
      if (cmd.accept) begin
        mode  <= mode_n;
        fault <= fault_n;
        drive <= drive_n;
        kind  <= kind_n;
        if (cwr) begin
          coeff_tab[idx[IW-1:0]] <= coeff_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code  <= code_n;
      prot  <= prot_n;
      tmr   <= tmr_n;
      store <= store_n;
      arg0  <= arg_byte[0];
      idx_r <= idx;
      pins  <= status_pins;
      sens  <= '0;
    end else if (cmd.sens_inc) begin
      sens <= sens + IW'(1);
    end
  end

  assign sel       = (kind == pucc_pkg::KIND_COEFF) ? idx_r[IW-1:0] : sens;
  assign cur_coeff = coeff_tab[idx_r[IW-1:0]];
  assign sum       = prod + (prod >> 12) + (prod >> 24);
  assign q0        = sum[27:12];

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      prod <= 28'(sample_tab[sel] * coeff_tab[sel]);
    end
    if (cmd.load_div) begin
      q <= q0;
      r <= prod - {q0, 12'd0} + 28'(q0);
    end else if (cmd.fix) begin
      q <= q + 16'd1;
      r <= r - pucc_pkg::SCALE_DIV;
    end
  end

  assign stat.kind      = kind;
  assign stat.fix_done  = (r < pucc_pkg::SCALE_DIV);
  assign stat.sens_last = (32'(sens) == SENSORS - 1);

  assign sbyte = {1'b0, !fault, pins[4:3], 1'b0, pins[2:0]};

  always_comb begin
    unique case (kind)
      pucc_pkg::KIND_SERIAL: head = pucc_pkg::serial_byte(cmd.k);
      pucc_pkg::KIND_COEFF: begin
        unique case (cmd.k[1:0])
          2'd0:    head = code;
          2'd1:    head = {1'b0, 1'b1, 5'd0, arg0};
          2'd2:    head = cur_coeff[7:0];
          default: head = cur_coeff[15:8];
        endcase
      end
      default: head = cmd.k[0] ? sbyte : code;
    endcase
  end

  always_comb begin
    unique case (cmd.emit_sel)
      pucc_pkg::SEL_HEAD: obyte = head;
      pucc_pkg::SEL_LO:   obyte = q[7:0];
      pucc_pkg::SEL_HI:   obyte = q[15:8];
      default:            obyte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      resp_byte     <= obyte;
      resp_last     <= cmd.last;
      rejected      <= (cmd.emit_sel == pucc_pkg::SEL_REJ);
      protect_reset <= (cmd.emit_sel != pucc_pkg::SEL_REJ) && prot;
      timer_start   <= (cmd.emit_sel != pucc_pkg::SEL_REJ) && tmr;
      coeff_store   <= (cmd.emit_sel != pucc_pkg::SEL_REJ) ? store : 3'd0;
    end
  end

endmodule

`default_nettype wire

/* src/power_unit_command_controller_top.sv */
// ----------------------------------------------------------------------------
// power_unit_command_controller_top
// Command slave of a power unit: mode interlocks, tables, drive levels.
// ----------------------------------------------------------------------------
// A command or a sample update is taken when start is high and busy is low.
// A sample update (req_type 1) writes the sample table and gives no result.
// A command gives a stream of response bytes, one per resp_valid strobe, the
// final one marked by resp_last; a refused command gives one byte of zero
// with rejected set. Results cannot be held off by the receiver: each byte
// is flagged by resp_valid for exactly one cycle.
// The first strobe is registered from the first header state, which follows
// the start state (from the start state itself for a refused command). Each
// scaled sample takes a multiply, a quotient estimate, a check plus at most
// one correction, and two bytes. busy stays high until the last strobe has
// gone; a sample update leaves busy low.
// Drive levels are steady outputs that change only when a command is taken.
// Reset clears mode, fault flag, drive levels and both tables.
// ----------------------------------------------------------------------------
`default_nettype none

module power_unit_command_controller_top #(
  parameter int SENSORS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [7:0]  opcode,
  input  wire logic [7:0]  frame_len,
  input  wire logic [7:0]  arg_byte,
  input  wire logic [15:0] coeff_value,
  input  wire logic [2:0]  sensor_index,
  input  wire logic [11:0] sample_value,
  input  wire logic        timer_active,
  input  wire logic [4:0]  status_pins,
  output logic             resp_valid,
  output logic [7:0]       resp_byte,
  output logic             resp_last,
  output logic             rejected,
  output logic             btr_off,
  output logic             gvi_power,
  output logic             bz_power_on,
  output logic             bz_power_off,
  output logic             charge_allow,
  output logic [2:0]       current_sel,
  output logic             protect_reset,
  output logic             timer_start,
  output logic [2:0]       coeff_store
);

  pucc_pkg::pucc_cmd_t  cmd;
  pucc_pkg::pucc_stat_t stat;
  logic [7:0]           drive;

  pucc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .resp_valid (resp_valid)
  );

  pucc_dp #(.SENSORS(SENSORS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .frame_len     (frame_len),
    .arg_byte      (arg_byte),
    .coeff_value   (coeff_value),
    .sensor_index  (sensor_index),
    .sample_value  (sample_value),
    .timer_active  (timer_active),
    .status_pins   (status_pins),
    .resp_byte     (resp_byte),
    .resp_last     (resp_last),
    .rejected      (rejected),
    .drive         (drive),
    .protect_reset (protect_reset),
    .timer_start   (timer_start),
    .coeff_store   (coeff_store)
  );

  assign btr_off      = drive[0];
  assign gvi_power    = drive[1];
  assign bz_power_on  = drive[2];
  assign bz_power_off = drive[3];
  assign charge_allow = drive[4];
  assign current_sel  = drive[7:5];

endmodule

`default_nettype wire

/* src/pucc_checker.sv */
// ----------------------------------------------------------------------------
// pucc_checker
// Port-level checks of the command controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_unit_command_controller_top_defines.svh"

module pucc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       req_type,
  input wire logic       resp_valid,
  input wire logic [7:0] resp_byte,
  input wire logic       resp_last,
  input wire logic       rejected
);

  `PUCC_ASSERT_NEXT(a_cmd_busy, start && !busy && !req_type, busy)
  `PUCC_ASSERT_NEXT(a_sample_quiet, start && !busy && req_type, !resp_valid)
  `PUCC_ASSERT_NOW(a_valid_busy, resp_valid, busy)
  `PUCC_ASSERT_NOW(a_reject_form, resp_valid && rejected, resp_last && resp_byte == 8'd0)
  `PUCC_ASSERT_NEXT(a_last_ends, resp_valid && resp_last, !resp_valid)

endmodule

bind power_unit_command_controller_top pucc_checker u_pucc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .req_type   (req_type),
  .resp_valid (resp_valid),
  .resp_byte  (resp_byte),
  .resp_last  (resp_last),
  .rejected   (rejected)
);

`default_nettype wire
